FILE: sv/bbc_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and bracket lookup functions for the bracket balance checker
package bbc_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int SYM_W       = 8;
   localparam int STATUS_W    = 3;
   localparam int POS_W       = 16;
   localparam int CLS_W       = 2;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
   localparam logic [SYM_W-1:0] SYM_END = 8'h00;

   localparam logic [STATUS_W-1:0] ST_RUNNING    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BALANCED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_CLOSER = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNCLOSED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd5;

   localparam logic [CLS_W-1:0] CLS_PAREN   = 2'd0;
   localparam logic [CLS_W-1:0] CLS_BRACE   = 2'd1;
   localparam logic [CLS_W-1:0] CLS_BRACKET = 2'd2;
   localparam logic [CLS_W-1:0] CLS_NONE    = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SYM_W-1:0]    required_symbol;
      logic [POS_W-1:0]    position;
   } rsp_type;

   function automatic logic [CLS_W-1:0] opener_class(input logic [SYM_W-1:0] c);
      case (c)
         8'h28:   opener_class = CLS_PAREN;
         8'h7B:   opener_class = CLS_BRACE;
         8'h5B:   opener_class = CLS_BRACKET;
         default: opener_class = CLS_NONE;
      endcase
   endfunction

   function automatic logic [CLS_W-1:0] closer_class(input logic [SYM_W-1:0] c);
      case (c)
         8'h29:   closer_class = CLS_PAREN;
         8'h7D:   closer_class = CLS_BRACE;
         8'h5D:   closer_class = CLS_BRACKET;
         default: closer_class = CLS_NONE;
      endcase
   endfunction

   function automatic logic [SYM_W-1:0] opener_char(input logic [CLS_W-1:0] k);
      case (k)
         CLS_PAREN:   opener_char = 8'h28;
         CLS_BRACE:   opener_char = 8'h7B;
         CLS_BRACKET: opener_char = 8'h5B;
         default:     opener_char = 8'h00;
      endcase
   endfunction

   function automatic logic [SYM_W-1:0] closer_char(input logic [CLS_W-1:0] k);
      case (k)
         CLS_PAREN:   closer_char = 8'h29;
         CLS_BRACE:   closer_char = 8'h7D;
         CLS_BRACKET: closer_char = 8'h5D;
         default:     closer_char = 8'h29;
      endcase
   endfunction

endpackage

FILE: sv/bbc_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the character and result streams
interface bbc_req_if;
   logic                      valid;
   logic                      ready;
   logic [bbc_pkg::SYM_W-1:0] symbol;

   modport source (output valid, output symbol, input ready);
   modport sink   (input valid, input symbol, output ready);
endinterface

interface bbc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bbc_pkg::STATUS_W-1:0] status;
   logic [bbc_pkg::SYM_W-1:0]    required_symbol;
   logic [bbc_pkg::POS_W-1:0]    position;

   modport source (output valid, output status, output required_symbol, output position,
                   input ready);
   modport sink   (input valid, input status, input required_symbol, input position,
                   output ready);
endinterface

FILE: sv/bbc_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read synchronous ram with registered read data
module bbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bbc_core.sv
`timescale 1ns / 1ps
// stack control: cached top entry, ram below it, forwarding and result generation
module bbc_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic [bbc_pkg::SYM_W-1:0] symbol,
   output bbc_pkg::rsp_type          result
);

   logic [bbc_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [bbc_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic                       failed_ff, failed_in;
   logic [bbc_pkg::CLS_W-1:0]  top_ff, top_in;
   logic                       fwd_hit_ff;
   logic [bbc_pkg::CLS_W-1:0]  fwd_data_ff;

   logic                       wr_en;
   logic [bbc_pkg::ADDR_W-1:0] wr_addr, rd_addr;
   logic [bbc_pkg::CNT_W-1:0]  wr_cnt, rd_cnt;
   logic [bbc_pkg::CLS_W-1:0]  rd_data, below;
   logic [bbc_pkg::CLS_W-1:0]  oc, cc;
   logic                       is_full, is_empty;

   assign oc       = bbc_pkg::opener_class(symbol);
   assign cc       = bbc_pkg::closer_class(symbol);
   assign is_full  = (count_ff == bbc_pkg::CNT_W'(bbc_pkg::STACK_DEPTH));
   assign is_empty = (count_ff == '0);

   // entry just under the cached top, with the last write forwarded
   assign below = fwd_hit_ff ? fwd_data_ff : rd_data;

   // push spills the old top into the ram slot count-1
   assign wr_cnt  = count_ff - bbc_pkg::CNT_W'(1);
   assign wr_addr = wr_cnt[bbc_pkg::ADDR_W-1:0];
   assign rd_cnt  = count_in - bbc_pkg::CNT_W'(2);
   assign rd_addr = rd_cnt[bbc_pkg::ADDR_W-1:0];

   always_comb begin
      count_in               = count_ff;
      pos_in                 = pos_ff;
      failed_in              = failed_ff;
      top_in                 = top_ff;
      wr_en                  = 1'b0;
      result.status          = bbc_pkg::ST_RUNNING;
      result.required_symbol = '0;
      result.position        = pos_ff;
      if (fire) begin
         if (symbol == bbc_pkg::SYM_END) begin
            if (failed_ff) begin
               result.status = bbc_pkg::ST_IGNORED;
            end else if (is_empty) begin
               result.status = bbc_pkg::ST_BALANCED;
            end else begin
               result.status          = bbc_pkg::ST_UNCLOSED;
               result.required_symbol = bbc_pkg::closer_char(top_ff);
            end
            count_in  = '0;
            pos_in    = '0;
            failed_in = 1'b0;
         end else begin
            if (pos_ff != bbc_pkg::POS_MAX) begin
               pos_in = pos_ff + bbc_pkg::POS_W'(1);
            end
            result.position = pos_in;
            if (failed_ff) begin
               result.status = bbc_pkg::ST_IGNORED;
            end else if (oc != bbc_pkg::CLS_NONE) begin
               if (is_full) begin
                  result.status = bbc_pkg::ST_OVERFLOW;
                  failed_in     = 1'b1;
               end else begin
                  wr_en    = !is_empty;
                  top_in   = oc;
                  count_in = count_ff + bbc_pkg::CNT_W'(1);
               end
            end else if (cc != bbc_pkg::CLS_NONE) begin
               if (is_empty || top_ff != cc) begin
                  result.status          = bbc_pkg::ST_BAD_CLOSER;
                  result.required_symbol = bbc_pkg::opener_char(cc);
                  failed_in              = 1'b1;
               end
               if (!is_empty) begin
                  count_in = count_ff - bbc_pkg::CNT_W'(1);
                  top_in   = below;
               end
            end
         end
      end
   end

   bbc_ram #(
      .WIDTH (bbc_pkg::CLS_W),
      .DEPTH (bbc_pkg::STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (top_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         pos_ff     <= '0;
         failed_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         pos_ff     <= pos_in;
         failed_ff  <= failed_in;
         fwd_hit_ff <= wr_en && (wr_addr == rd_addr);
      end
      top_ff      <= top_in;
      fwd_data_ff <= top_ff;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bbc_pkg::CNT_W'(bbc_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      fire && symbol == bbc_pkg::SYM_END |=> count_ff == '0 && pos_ff == '0 && !failed_ff)
      else $error("terminator did not clear expression state");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      fire && result.status == bbc_pkg::ST_OVERFLOW |-> is_full ##1 failed_ff)
      else $error("overflow reported without a full stack");

endmodule

FILE: sv/bbc_out_buf.sv
`timescale 1ns / 1ps
// result output register plus skid stage
module bbc_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  bbc_pkg::rsp_type in_data,
   output logic             in_ready,
   output logic             out_valid,
   output bbc_pkg::rsp_type out_data,
   input  logic             out_ready
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   bbc_pkg::rsp_type out_data_ff, out_data_in;
   bbc_pkg::rsp_type skid_data_ff, skid_data_in;
   logic             take;

   assign in_ready  = !skid_valid_ff;
   assign take      = out_valid_ff && out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid && in_ready) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a beat while the output register is empty");

endmodule

FILE: sv/bracket_balance_checker.sv
`timescale 1ns / 1ps
// top level of the bracket balance checker
//
// takes one character beat per cycle on req_bus and returns exactly one result
// beat per character on rsp_bus, in order. '(' '{' '[' push the class of their
// closer, ')' '}' ']' pop and compare, byte 0 ends the expression, reports
// balanced / unclosed / ignored and clears the state for the next expression.
// a sustained rate of one character per cycle while rsp_bus keeps up: the top
// of the stack sits in a register and the entry below it is read from the
// stack ram every cycle, so the registered ram read is hidden and back-to-back
// pushes and pops need no bubble; a write landing on the slot being read is
// forwarded. each result is formed combinationally and then registered. a
// result register and a skid stage sit in front of rsp_bus, so req_bus keeps
// taking characters while a result waits; req_bus.ready drops only when both
// hold a beat. no clearing pass after reset: the stack ram is only read below
// the stack count, which reset clears.
module bracket_balance_checker (
   input  logic           clock,
   input  logic           reset,
   bbc_req_if.sink        req_bus,
   bbc_rsp_if.source      rsp_bus
);

   logic             fire;
   logic             buf_ready;
   bbc_pkg::rsp_type core_result;
   bbc_pkg::rsp_type out_data;

   // a character beat is taken whenever the skid stage is free
   assign req_bus.ready = buf_ready;
   assign fire          = req_bus.valid && buf_ready;

   // stack engine: ram-backed stack with cached top
   bbc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .symbol (req_bus.symbol),
      .result (core_result)
   );

   // result register and skid stage
   bbc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fire),
      .in_data   (core_result),
      .in_ready  (buf_ready),
      .out_valid (rsp_bus.valid),
      .out_data  (out_data),
      .out_ready (rsp_bus.ready)
   );

   assign rsp_bus.status          = out_data.status;
   assign rsp_bus.required_symbol = out_data.required_symbol;
   assign rsp_bus.position        = out_data.position;

endmodule

FILE: dv/bbc_chars_pkg.sv
`timescale 1ns / 1ps
// ascii bracket characters indexed by bracket class, shared by the testbench files
package bbc_chars_pkg;

   // index 0 round, 1 curly, 2 square: '(' '{' '[' and ')' '}' ']'
   localparam logic [2:0][7:0] OPENERS = {8'h5B, 8'h7B, 8'h28};
   localparam logic [2:0][7:0] CLOSERS = {8'h5D, 8'h7D, 8'h29};

endpackage

FILE: dv/bbc_nest_checker.sv
`timescale 1ns / 1ps
// scoreboard that predicts and checks every result beat of the bracket balance checker
module bbc_nest_checker
   import bbc_pkg::*;
   import bbc_chars_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   bbc_req_if               req_mon,
   bbc_rsp_if               rsp_mon,
   output int               error_count,
   output int               outstanding,
   output logic [7:0][31:0] status_tally
);

   localparam int PRINT_LIMIT = 200;

   // predicted nesting state
   logic [CLS_W-1:0] closer_stack [STACK_DEPTH];
   logic [CNT_W-1:0] nest_depth;
   logic [POS_W-1:0] char_count;
   logic             expr_failed;

   rsp_type          expected_rsp [$];
   int               mismatches;
   logic [7:0][31:0] tally;

   // advance the nesting state by one character, return the result it causes
   function automatic rsp_type nest_step(input logic [SYM_W-1:0] sym);
      rsp_type          r;
      logic [CLS_W-1:0] open_k;
      logic [CLS_W-1:0] close_k;
      logic             bad;
      r.status          = ST_RUNNING;
      r.required_symbol = '0;
      open_k            = CLS_NONE;
      close_k           = CLS_NONE;
      for (int k = 0; k < 3; k++) begin
         if (sym == OPENERS[k]) open_k = CLS_W'(k);
         if (sym == CLOSERS[k]) close_k = CLS_W'(k);
      end

      if (sym == SYM_END) begin
         if (expr_failed) begin
            r.status = ST_IGNORED;
         end else if (nest_depth == '0) begin
            r.status = ST_BALANCED;
         end else begin
            r.status          = ST_UNCLOSED;
            r.required_symbol = CLOSERS[closer_stack[nest_depth - 1'b1]];
         end
         r.position  = char_count;
         nest_depth  = '0;
         char_count  = '0;
         expr_failed = 1'b0;
         return r;
      end

      if (char_count != POS_MAX) char_count = char_count + 1'b1;
      r.position = char_count;

      if (expr_failed) begin
         r.status = ST_IGNORED;
      end else if (open_k != CLS_NONE) begin
         if (nest_depth == CNT_W'(STACK_DEPTH)) begin
            r.status    = ST_OVERFLOW;
            expr_failed = 1'b1;
         end else begin
            closer_stack[nest_depth] = open_k;
            nest_depth               = nest_depth + 1'b1;
         end
      end else if (close_k != CLS_NONE) begin
         bad = (nest_depth == '0);
         if (!bad) begin
            nest_depth = nest_depth - 1'b1;
            bad        = (closer_stack[nest_depth] != close_k);
         end
         if (bad) begin
            r.status          = ST_BAD_CLOSER;
            r.required_symbol = OPENERS[close_k];
            expr_failed       = 1'b1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         nest_depth  = '0;
         char_count  = '0;
         expr_failed = 1'b0;
         mismatches  = 0;
         tally       = '0;
         expected_rsp.delete();
      end else begin
         // results first: a result never belongs to a character taken on the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status          = rsp_mon.status;
            got.required_symbol = rsp_mon.required_symbol;
            got.position        = rsp_mon.position;
            tally[got.status]   = tally[got.status] + 1;
            if (expected_rsp.size() == 0) begin
               if (mismatches < PRINT_LIMIT)
                  $display("%0t unexpected result beat: status %0d symbol %h position %0d",
                           $time, got.status, got.required_symbol, got.position);
               mismatches++;
            end else begin
               want = expected_rsp.pop_front();
               if (got.status != want.status) begin
                  if (mismatches < PRINT_LIMIT)
                     $display("%0t status mismatch: expected %0d, actual %0d",
                              $time, want.status, got.status);
                  mismatches++;
               end
               if (got.required_symbol != want.required_symbol) begin
                  if (mismatches < PRINT_LIMIT)
                     $display("%0t required_symbol mismatch: expected %h, actual %h",
                              $time, want.required_symbol, got.required_symbol);
                  mismatches++;
               end
               if (got.position != want.position) begin
                  if (mismatches < PRINT_LIMIT)
                     $display("%0t position mismatch: expected %0d, actual %0d",
                              $time, want.position, got.position);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_rsp.push_back(nest_step(req_mon.symbol));
      end
      error_count  <= mismatches;
      status_tally <= tally;
      outstanding  <= expected_rsp.size();
   end

endmodule

FILE: dv/tb_bracket_balance_checker.sv
`timescale 1ns / 1ps
// testbench top: stimulus, receiver stalls and verdict for the bracket balance checker
module tb_bracket_balance_checker;
   import bbc_pkg::*;
   import bbc_chars_pkg::*;

   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 12;
   localparam int LIMIT_CYCLES    = 2_000_000;
   localparam int RANDOM_ITEMS    = 800;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int SETTLE_CYCLES   = 10;
   localparam int MAX_OPEN        = 40;
   localparam logic [SYM_W-1:0] FILLER = 8'h78;  // 'x'

   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_type;
   typedef enum int {DMG_SWAP_CLOSER, DMG_EXTRA_CLOSER, DMG_CUT_TAIL, DMG_STRAY_OPENER}
      damage_type;

   logic             clock;
   logic             reset;
   int               error_count;
   int               outstanding;
   logic [7:0][31:0] status_tally;

   bbc_req_if req_bus ();
   bbc_rsp_if rsp_bus ();

   bracket_balance_checker dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bbc_nest_checker nest_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_bus),
      .rsp_mon      (rsp_bus),
      .error_count  (error_count),
      .outstanding  (outstanding),
      .status_tally (status_tally)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // hard stop in case the block hangs or loses results
   initial begin
      #(CLOCK_PERIOD * LIMIT_CYCLES);
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // result side: ready follows a pattern, re-picked at random from four kinds,
   // and on request it holds off for a long stretch so the block backs up
   // ---------------------------------------------------------------------------
   bit             hold_off_req = 1'b0;
   int             rx_cycle;
   int             hold_left;
   rx_pattern_type rx_pattern;

   initial begin
      rsp_bus.ready <= 1'b0;
      rx_cycle   = 0;
      hold_left  = 0;
      rx_pattern = RX_OPEN;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle % 300 == 0) rx_pattern = rx_pattern_type'($urandom_range(0, 3));
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (rx_pattern)
               RX_OPEN:  rsp_bus.ready <= 1'b1;
               RX_LIGHT: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               RX_HEAVY: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default:  rsp_bus.ready <= ((rx_cycle % 16) < 8);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // character side
   // ---------------------------------------------------------------------------
   int               burst_left;
   bit               steady_send;   // no gaps while set
   int               chars_sent;
   int               expressions_sent;
   logic [SYM_W-1:0] expr_text [$];

   // one character beat; bursts of random length with random gaps between them
   task automatic send_char(input logic [SYM_W-1:0] sym);
      int gap;
      if (!steady_send && burst_left == 0) begin
         gap = $urandom_range(0, 9);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      req_bus.valid  <= 1'b1;
      req_bus.symbol <= sym;
      do @(posedge clock); while (!req_bus.ready);
      if (burst_left > 0) burst_left--;
      chars_sent++;
   endtask

   // the composed text followed by the terminator byte
   task automatic send_expression();
      foreach (expr_text[i]) send_char(expr_text[i]);
      send_char(SYM_END);
      expressions_sent++;
   endtask

   task automatic send_string(input string s);
      expr_text.delete();
      for (int i = 0; i < s.len(); i++) expr_text.push_back(s[i]);
      send_expression();
   endtask

   // sender pauses until every predicted result has been seen
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // any nonzero byte that is not a bracket
   function automatic logic [SYM_W-1:0] plain_byte();
      logic [SYM_W-1:0] b;
      bit               clash;
      do begin
         b     = SYM_W'($urandom_range(1, 255));
         clash = 1'b0;
         for (int k = 0; k < 3; k++)
            if (b == OPENERS[k] || b == CLOSERS[k]) clash = 1'b1;
      end while (clash);
      return b;
   endfunction

   // random expression: mostly properly nested with filler between the brackets,
   // sometimes damaged in one spot, sometimes plain noise rich in brackets
   task automatic compose_expression(input int len, input bit noisy);
      logic [CLS_W-1:0] open_k [$];
      logic [CLS_W-1:0] k;
      int               pick;
      int               pos;
      expr_text.delete();
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         k    = CLS_W'($urandom_range(0, 2));
         if (noisy) begin
            if (pick < 25)      expr_text.push_back(OPENERS[k]);
            else if (pick < 50) expr_text.push_back(CLOSERS[k]);
            else                expr_text.push_back(SYM_W'($urandom_range(1, 255)));
         end else if (pick < 40 && open_k.size() < MAX_OPEN) begin
            open_k.push_back(k);
            expr_text.push_back(OPENERS[k]);
         end else if (pick < 75 && open_k.size() > 0) begin
            expr_text.push_back(CLOSERS[open_k.pop_back()]);
         end else begin
            expr_text.push_back(plain_byte());
         end
      end
      while (open_k.size() > 0) expr_text.push_back(CLOSERS[open_k.pop_back()]);

      if (!noisy && expr_text.size() > 0 && $urandom_range(0, 99) < 30) begin
         pos = $urandom_range(0, expr_text.size() - 1);
         k   = CLS_W'($urandom_range(0, 2));
         case (damage_type'($urandom_range(0, 3)))
            DMG_SWAP_CLOSER:  expr_text[pos] = CLOSERS[k];
            DMG_EXTRA_CLOSER: expr_text.insert(pos, CLOSERS[k]);
            DMG_CUT_TAIL:     while (expr_text.size() > pos) void'(expr_text.pop_back());
            default:          expr_text[pos] = OPENERS[k];
         endcase
      end
   endtask

   // n openers of random class, closed again innermost first when asked
   task automatic compose_nest(input int n, input bit close_all);
      logic [CLS_W-1:0] open_k [$];
      logic [CLS_W-1:0] k;
      expr_text.delete();
      repeat (n) begin
         k = CLS_W'($urandom_range(0, 2));
         open_k.push_back(k);
         expr_text.push_back(OPENERS[k]);
      end
      if (close_all)
         while (open_k.size() > 0) expr_text.push_back(CLOSERS[open_k.pop_back()]);
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   int random_start;

   initial begin
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.symbol <= '0;
      burst_left       = 0;
      steady_send      = 1'b0;
      chars_sent       = 0;
      expressions_sent = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty expression, every bracket, closer on empty stack with
      // characters ignored after it, closer of the wrong class, unclosed at end
      send_string("");
      send_string("(){}[]");
      send_string("]x");
      send_string("(]");
      send_string("{(");
      // byte extremes and odd bits, all plain characters
      expr_text = '{8'hFF, 8'h01, 8'h80, 8'h7F};
      send_expression();
      wait_for_results();

      // stack exactly full and left open, full and unwound, one push past full
      compose_nest(STACK_DEPTH, 1'b0);
      send_expression();
      compose_nest(STACK_DEPTH, 1'b1);
      send_expression();
      compose_nest(STACK_DEPTH + 1, 1'b0);
      expr_text.push_back(FILLER);
      expr_text.push_back(CLOSERS[CLS_PAREN]);
      send_expression();

      // result side holds off while characters keep coming: input must stall
      hold_off_req = 1'b1;
      steady_send  = 1'b1;
      compose_expression(48, 1'b0);
      send_expression();
      steady_send = 1'b0;
      wait_for_results();

      // random expressions, mostly well formed, a few long ones
      random_start = chars_sent;
      while (chars_sent - random_start < RANDOM_ITEMS) begin
         steady_send = ($urandom_range(0, 4) == 0);
         compose_expression(($urandom_range(0, 9) == 0) ? $urandom_range(25, 90)
                                                          : $urandom_range(0, 24),
                            ($urandom_range(0, 9) == 0));
         send_expression();
         if ($urandom_range(0, 39) == 0) wait_for_results();
      end
      steady_send = 1'b0;

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d characters in %0d expressions, full and overflowing stack,",
               chars_sent, expressions_sent);
      $display("bad closers, unclosed ends and a long result hold-off; results %0d running, %0d %s",
               status_tally[ST_RUNNING], status_tally[ST_BALANCED], "balanced");
      if (error_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
